@@ rtl/cqr_pkg.sv @@
`default_nettype none

package cqr_pkg;

    // Widths fixed by the item format
    localparam int THREAD_BITS = 8;
    localparam int CREDIT_OUT_BITS = 8;
    localparam int COUNT_OUT_BITS = 5;
    localparam int INDEX_BITS = 4;
    localparam int ACTION_BITS = 3;

    // Action codes carried by an input beat
    typedef enum logic [ACTION_BITS-1:0] {
        ACT_SORTED    = 3'd0,
        ACT_APPEND    = 3'd1,
        ACT_PREPEND   = 3'd2,
        ACT_POP_FRONT = 3'd3,
        ACT_POP_BACK  = 3'd4,
        ACT_READ      = 3'd5
    } t_action;

    // Per-cell move command, highest priority first
    typedef struct packed {
        logic load_new;     // take the entry being added
        logic take_left;    // take the entry of the cell nearer the head
        logic take_right;   // take the entry of the cell nearer the tail
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ rtl/cqr_cell.sv @@
`default_nettype none

module cqr_cell
    import cqr_pkg::*;
#(
    parameter int KEY_BITS = 8
) (
    input  wire logic                   i_clk,
    input  wire t_cell_ctl              i_ctl,
    input  wire logic [THREAD_BITS-1:0] i_new_thread,
    input  wire logic [KEY_BITS-1:0]    i_new_credit,
    input  wire logic [THREAD_BITS-1:0] i_left_thread,
    input  wire logic [KEY_BITS-1:0]    i_left_credit,
    input  wire logic [THREAD_BITS-1:0] i_right_thread,
    input  wire logic [KEY_BITS-1:0]    i_right_credit,
    output logic      [THREAD_BITS-1:0] o_thread,
    output logic      [KEY_BITS-1:0]    o_credit
);

    logic [THREAD_BITS-1:0] r_thread;
    logic [KEY_BITS-1:0]    r_credit;

    // Load, shift toward the tail, shift toward the head, or hold
    always_ff @(posedge i_clk) begin
        priority if (i_ctl.load_new) begin
            r_thread <= i_new_thread;
            r_credit <= i_new_credit;
        end else if (i_ctl.take_left) begin
            r_thread <= i_left_thread;
            r_credit <= i_left_credit;
        end else if (i_ctl.take_right) begin
            r_thread <= i_right_thread;
            r_credit <= i_right_credit;
        end else begin
            r_thread <= r_thread;
            r_credit <= r_credit;
        end
    end

    assign o_thread = r_thread;
    assign o_credit = r_credit;

endmodule

`default_nettype wire

@@ rtl/credit_sorted_ready_queue.sv @@
`default_nettype none

// Ready queue of up to DEPTH (thread id, credit) entries kept in a row of
// cells, head in cell 0. Every command shifts, loads or reads all cells in
// parallel, so one command is taken each clock: busy stays low and a start
// beat is always accepted. Its result appears on the o_ ports, marked by
// o_done, in the cycle after the start beat and only in that cycle;
// the receiver cannot stall and must take it then. The critical path is the
// per-cell credit compare feeding the first-match search along the row for
// a sorted add. Contents are undefined after reset; only the count and o_done clear.

module credit_sorted_ready_queue
    import cqr_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [ACTION_BITS-1:0]     i_action,
    input  wire logic [THREAD_BITS-1:0]     i_thread_id,
    input  wire logic [CREDIT_OUT_BITS-1:0] i_credit,
    input  wire logic [INDEX_BITS-1:0]      i_index,
    output logic                            o_done,
    output logic                            o_ok,
    output logic [THREAD_BITS-1:0]          o_thread_out,
    output logic [CREDIT_OUT_BITS-1:0]      o_credit_out,
    output logic [COUNT_OUT_BITS-1:0]       o_count
);

    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [CNT_BITS-1:0]    r_count, n_count;
    logic                   r_done;
    logic                   r_ok, n_ok;
    logic [THREAD_BITS-1:0] r_thread, n_thread;
    logic [KEY_BITS-1:0]    r_credit, n_credit;

    logic [THREAD_BITS-1:0] w_thread [DEPTH];
    logic [KEY_BITS-1:0]    w_credit [DEPTH];
    t_cell_ctl              w_ctl    [DEPTH];

    logic [KEY_BITS-1:0]    w_key;
    t_action                w_act;
    logic                   w_full;
    logic                   w_empty;
    logic                   w_tail_le;
    logic [DEPTH-1:0]       w_ge;
    logic [DEPTH-1:0]       w_pre;
    logic [DEPTH-1:0]       w_after;
    logic [DEPTH-1:0]       w_sel;

    assign w_key   = KEY_BITS'(i_credit);
    assign w_act   = t_action'(i_action);
    assign w_full  = (32'(r_count) == DEPTH);
    assign w_empty = (r_count == '0);
    assign busy    = 1'b0;

    // Compare the new key against every occupied cell
    always_comb begin
        w_tail_le = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            w_ge[i] = (i < 32'(r_count)) && (w_credit[i] >= w_key);
            if ((i + 1) == 32'(r_count) && (w_credit[i] <= w_key)) begin
                w_tail_le = 1'b1;
            end
        end
    end

    // Mark cells at or past the first occupied cell with credit >= key
    always_comb begin
        w_pre[0] = w_ge[0];
        for (int i = 1; i < DEPTH; i++) begin
            w_pre[i] = w_pre[i-1] | w_ge[i];
        end
    end

    // Decide the insert point and build each cell's move command
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_after[i] = 1'b0;
            w_sel[i]   = 1'b0;
        end
        n_count = r_count;
        n_ok    = 1'b0;
        if (start && !busy) begin
            unique case (w_act)
                ACT_SORTED, ACT_APPEND, ACT_PREPEND: begin
                    if (!w_full) begin
                        n_ok    = 1'b1;
                        n_count = r_count + CNT_BITS'(1);
                        for (int i = 0; i < DEPTH; i++) begin
                            if (w_act == ACT_PREPEND) begin
                                w_after[i] = 1'b1;
                            end else if (w_act == ACT_APPEND || w_empty || w_tail_le) begin
                                w_after[i] = (i >= 32'(r_count));
                            end else begin
                                w_after[i] = w_pre[i];
                            end
                        end
                    end
                end
                ACT_POP_FRONT, ACT_POP_BACK: begin
                    if (!w_empty) begin
                        n_ok    = 1'b1;
                        n_count = r_count - CNT_BITS'(1);
                        for (int i = 0; i < DEPTH; i++) begin
                            if (w_act == ACT_POP_FRONT) begin
                                w_sel[i] = (i == 0);
                            end else begin
                                w_sel[i] = ((i + 1) == 32'(r_count));
                            end
                        end
                    end
                end
                ACT_READ: begin
                    if (32'(i_index) < 32'(r_count) && 32'(i_index) < DEPTH) begin
                        n_ok = 1'b1;
                        for (int i = 0; i < DEPTH; i++) begin
                            w_sel[i] = (i == 32'(i_index));
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        for (int i = 0; i < DEPTH; i++) begin
            w_ctl[i].load_new   = w_after[i] && ((i == 0) ? 1'b1 : !w_after[(i == 0) ? 0 : i-1]);
            w_ctl[i].take_left  = w_after[i] && ((i == 0) ? 1'b0 : w_after[(i == 0) ? 0 : i-1]);
            w_ctl[i].take_right = n_ok && (w_act == ACT_POP_FRONT) && (i < DEPTH - 1);
        end
    end

    // Pick the entry leaving or being read
    always_comb begin
        n_thread = '0;
        n_credit = '0;
        for (int i = 0; i < DEPTH; i++) begin
            n_thread = n_thread | (w_thread[i] & {THREAD_BITS{w_sel[i]}});
            n_credit = n_credit | (w_credit[i] & {KEY_BITS{w_sel[i]}});
        end
    end

    // Row of storage cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam int LEFT  = (g == 0) ? 0 : g - 1;
        localparam int RIGHT = (g == DEPTH - 1) ? g : g + 1;

        cqr_cell #(
            .KEY_BITS(KEY_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl[g]),
            .i_new_thread  (i_thread_id),
            .i_new_credit  (w_key),
            .i_left_thread (w_thread[LEFT]),
            .i_left_credit (w_credit[LEFT]),
            .i_right_thread(w_thread[RIGHT]),
            .i_right_credit(w_credit[RIGHT]),
            .o_thread      (w_thread[g]),
            .o_credit      (w_credit[g])
        );
    end

    // Hold count and result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= start && !busy;
        end
        r_ok     <= n_ok;
        r_thread <= n_thread;
        r_credit <= n_credit;
    end

    assign o_done       = r_done;
    assign o_ok         = r_ok;
    assign o_thread_out = r_thread;
    assign o_credit_out = CREDIT_OUT_BITS'(r_credit);
    assign o_count      = COUNT_OUT_BITS'(r_count);

endmodule

`default_nettype wire

@@ dv/tb_credit_sorted_ready_queue.sv @@
`default_nettype none

module tb_credit_sorted_ready_queue;
    import cqr_pkg::*;

    localparam int DEPTH      = 16;
    localparam int STALL_MAX  = 1000;
    localparam int DRAIN_WAIT = 4;

    // Codes the block must ignore
    localparam logic [ACTION_BITS-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACTION_BITS-1:0] ACT_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [THREAD_BITS-1:0]     thread;
        logic [CREDIT_OUT_BITS-1:0] credit;
    } slot_t;

    typedef struct packed {
        logic                       ok;
        logic [THREAD_BITS-1:0]     thread;
        logic [CREDIT_OUT_BITS-1:0] credit;
        logic [COUNT_OUT_BITS-1:0]  count;
    } outcome_t;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic [ACTION_BITS-1:0]     i_action;
    logic [THREAD_BITS-1:0]     i_thread_id;
    logic [CREDIT_OUT_BITS-1:0] i_credit;
    logic [INDEX_BITS-1:0]      i_index;
    logic                       o_done;
    logic                       o_ok;
    logic [THREAD_BITS-1:0]     o_thread_out;
    logic [CREDIT_OUT_BITS-1:0] o_credit_out;
    logic [COUNT_OUT_BITS-1:0]  o_count;

    // Shadow copy of the queue contents, head at position 0
    slot_t    ready_slots[$];
    outcome_t pending_outcomes[$];

    logic idle_on;
    int   fail_count;
    int   beats_taken;
    int   results_seen;
    int   adds_refused;
    int   empty_pops;
    int   full_hits;
    int   stall_cycles;

    credit_sorted_ready_queue #(
        .DEPTH    (DEPTH),
        .KEY_BITS (8)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_thread_id  (i_thread_id),
        .i_credit     (i_credit),
        .i_index      (i_index),
        .o_done       (o_done),
        .o_ok         (o_ok),
        .o_thread_out (o_thread_out),
        .o_credit_out (o_credit_out),
        .o_count      (o_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one command to the shadow queue and return the result it yields
    function automatic outcome_t apply_queue_action(
        input logic [ACTION_BITS-1:0]     act,
        input logic [THREAD_BITS-1:0]     tid,
        input logic [CREDIT_OUT_BITS-1:0] cr,
        input logic [INDEX_BITS-1:0]      idx
    );
        outcome_t r;
        slot_t    s;
        int       pos;
        r = '0;
        s.thread = tid;
        s.credit = cr;
        case (act)
            ACT_SORTED, ACT_APPEND, ACT_PREPEND: begin
                if (ready_slots.size() < DEPTH) begin
                    if (act == ACT_PREPEND) begin
                        pos = 0;
                    end else if (act == ACT_APPEND || ready_slots.size() == 0 ||
                                 ready_slots[ready_slots.size()-1].credit <= cr) begin
                        pos = ready_slots.size();
                    end else begin
                        // insert ahead of the first entry with credit >= new
                        pos = 0;
                        while (pos < ready_slots.size() && ready_slots[pos].credit < cr)
                            pos++;
                    end
                    ready_slots.insert(pos, s);
                    r.ok = 1'b1;
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK: begin
                if (ready_slots.size() > 0) begin
                    if (act == ACT_POP_FRONT)
                        s = ready_slots.pop_front();
                    else
                        s = ready_slots.pop_back();
                    r.ok     = 1'b1;
                    r.thread = s.thread;
                    r.credit = s.credit;
                end
            end
            ACT_READ: begin
                if (idx < ready_slots.size()) begin
                    r.ok     = 1'b1;
                    r.thread = ready_slots[idx].thread;
                    r.credit = ready_slots[idx].credit;
                end
            end
            default: ;
        endcase
        r.count = COUNT_OUT_BITS'(ready_slots.size());
        return r;
    endfunction

    // Predict on every accepted beat, then check the result strobe
    always @(posedge i_clk) begin
        outcome_t want;
        outcome_t got;
        if (i_rst_n && start && !busy) begin
            beats_taken++;
            if ((i_action == ACT_SORTED || i_action == ACT_APPEND ||
                 i_action == ACT_PREPEND) && ready_slots.size() == DEPTH)
                adds_refused++;
            if ((i_action == ACT_POP_FRONT || i_action == ACT_POP_BACK) &&
                ready_slots.size() == 0)
                empty_pops++;
            pending_outcomes.push_back(
                apply_queue_action(i_action, i_thread_id, i_credit, i_index));
            if (ready_slots.size() == DEPTH)
                full_hits++;
        end
        if (i_rst_n && o_done) begin
            results_seen++;
            got = {o_ok, o_thread_out, o_credit_out, o_count};
            if (pending_outcomes.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display({"ERROR: result with nothing pending: ",
                              "ok=%0d thr=%0d cr=%0d cnt=%0d"},
                             got.ok, got.thread, got.credit, got.count);
            end else begin
                want = pending_outcomes.pop_front();
                if (got != want) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"ERROR: result %0d exp ok=%0d thr=%0d cr=%0d cnt=%0d, ",
                                  "got ok=%0d thr=%0d cr=%0d cnt=%0d"},
                                 results_seen, want.ok, want.thread, want.credit,
                                 want.count, got.ok, got.thread, got.credit, got.count);
                end
            end
        end
    end

    // Abort if nothing moves for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_MAX) begin
            $display("ERROR: no activity for %0d cycles", STALL_MAX);
            $display("FAIL credit_sorted_ready_queue");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Drive one beat; caller and return both sit at a falling edge
    task automatic send_beat(
        input logic [ACTION_BITS-1:0]     act,
        input logic [THREAD_BITS-1:0]     tid,
        input logic [CREDIT_OUT_BITS-1:0] cr,
        input logic [INDEX_BITS-1:0]      idx
    );
        if (idle_on) begin
            while ($urandom_range(99) < 21) begin
                start       = 1'b0;
                // junk on the payload while start is low
                i_action    = ACTION_BITS'($urandom);
                i_thread_id = THREAD_BITS'($urandom);
                i_credit    = CREDIT_OUT_BITS'($urandom);
                i_index     = INDEX_BITS'($urandom);
                @(negedge i_clk);
            end
        end
        start       = 1'b1;
        i_action    = act;
        i_thread_id = tid;
        i_credit    = cr;
        i_index     = idx;
        do
            @(posedge i_clk);
        while (busy);
        @(negedge i_clk);
    endtask

    // Pops, reads and spare codes on an empty queue
    task automatic test_empty_queue();
        send_beat(ACT_POP_FRONT, 8'hff, 8'hff, 4'hf);
        send_beat(ACT_POP_BACK, 8'h00, 8'h00, 4'h0);
        send_beat(ACT_READ, 8'h12, 8'h34, 4'h0);
        send_beat(ACT_SPARE_6, 8'h55, 8'haa, 4'h5);
        send_beat(ACT_SPARE_7, 8'haa, 8'h55, 4'ha);
    endtask

    // Sorted insertion at tail, head and middle, equal keys, append, prepend
    task automatic test_sorted_order();
        send_beat(ACT_SORTED, 8'd1, 8'd128, 4'd0);
        send_beat(ACT_SORTED, 8'd2, 8'd255, 4'd0);
        send_beat(ACT_SORTED, 8'd3, 8'd0, 4'd0);
        send_beat(ACT_SORTED, 8'd4, 8'd128, 4'd0);
        send_beat(ACT_SORTED, 8'd5, 8'd255, 4'd0);
        send_beat(ACT_APPEND, 8'd6, 8'd10, 4'd0);
        send_beat(ACT_PREPEND, 8'd255, 8'd200, 4'd0);
        send_beat(ACT_READ, 8'd0, 8'd0, 4'd0);
        send_beat(ACT_READ, 8'd0, 8'd0, 4'd6);
        send_beat(ACT_READ, 8'd0, 8'd0, 4'd7);
        send_beat(ACT_POP_FRONT, 8'd0, 8'd0, 4'd0);
        send_beat(ACT_POP_BACK, 8'd0, 8'd0, 4'd0);
        send_beat(ACT_SPARE_7, 8'd0, 8'd0, 4'd0);
    endtask

    // Fill to capacity, bounce every add kind off it, read the last slot
    task automatic test_full_queue();
        while (ready_slots.size() < DEPTH)
            send_beat(ACT_SORTED, THREAD_BITS'($urandom), CREDIT_OUT_BITS'($urandom),
                      4'd0);
        send_beat(ACT_SORTED, 8'd7, 8'd0, 4'd0);
        send_beat(ACT_APPEND, 8'd8, 8'd255, 4'd0);
        send_beat(ACT_PREPEND, 8'd9, 8'd1, 4'd0);
        send_beat(ACT_READ, 8'd0, 8'd0, 4'd15);
        send_beat(ACT_POP_BACK, 8'd0, 8'd0, 4'd0);
        send_beat(ACT_PREPEND, 8'd255, 8'd255, 4'd0);
        send_beat(ACT_READ, 8'd0, 8'd0, 4'd0);
        while (ready_slots.size() > 0)
            send_beat(ACT_POP_FRONT, 8'd0, 8'd0, 4'd0);
    endtask

    // Random mix with a fill/drain bias that flips so both ends get visited
    task automatic test_random_mix(input int n_items);
        int                         add_pct;
        int                         sel;
        logic [ACTION_BITS-1:0]     act;
        logic [CREDIT_OUT_BITS-1:0] cr;
        logic [INDEX_BITS-1:0]      idx;
        add_pct = 75;
        for (int n = 0; n < n_items; n++) begin
            idle_on = (n >= 200);
            if (n % 60 == 59)
                add_pct = (add_pct > 50) ? 25 : 75;
            sel = $urandom_range(99);
            if (sel < 3) begin
                act = $urandom_range(1) ? ACT_SPARE_7 : ACT_SPARE_6;
            end else if (sel < 16) begin
                act = ACT_READ;
            end else if ($urandom_range(99) < add_pct) begin
                sel = $urandom_range(9);
                act = (sel < 6) ? ACT_SORTED : (sel < 8) ? ACT_APPEND : ACT_PREPEND;
            end else begin
                act = $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
            end
            // narrow key band now and then to force ties
            if ($urandom_range(1))
                cr = CREDIT_OUT_BITS'($urandom_range(100, 104));
            else
                cr = CREDIT_OUT_BITS'($urandom);
            if (ready_slots.size() > 0 && $urandom_range(99) < 70)
                idx = INDEX_BITS'($urandom_range(ready_slots.size() - 1));
            else
                idx = INDEX_BITS'($urandom);
            send_beat(act, THREAD_BITS'($urandom), cr, idx);
        end
    endtask

    initial begin
        int waited;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_action     = '0;
        i_thread_id  = '0;
        i_credit     = '0;
        i_index      = '0;
        idle_on      = 1'b1;
        fail_count   = 0;
        beats_taken  = 0;
        results_seen = 0;
        adds_refused = 0;
        empty_pops   = 0;
        full_hits    = 0;
        stall_cycles = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_queue();
        test_sorted_order();
        test_full_queue();
        test_random_mix(700);

        // Drain, then keep the clock running idle so that any stray strobe shows
        start  = 1'b0;
        waited = 0;
        while (pending_outcomes.size() != 0 && waited < STALL_MAX) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (pending_outcomes.size() != 0) begin
            fail_count++;
            $display("ERROR: %0d results never arrived", pending_outcomes.size());
        end

        $display("Ran %0d beats, checked %0d results, %0d mismatches", beats_taken,
                 results_seen, fail_count);
        $display("Refused adds on full: %0d, pops on empty: %0d, beats leaving it full: %0d",
                 adds_refused, empty_pops, full_hits);
        if (fail_count == 0)
            $display("PASS credit_sorted_ready_queue");
        else
            $display("FAIL credit_sorted_ready_queue");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/cqr_pkg.sv
rtl/cqr_cell.sv
rtl/credit_sorted_ready_queue.sv
dv/tb_credit_sorted_ready_queue.sv
